FILE: sv/substring_replace_stream_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for substring_replace_stream
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SUBSTRING_REPLACE_STREAM_MACROS_SVH
`define SUBSTRING_REPLACE_STREAM_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every edge out of reset
`define SRS_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// pre at one edge implies post at the next
`define SRS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define SRS_ASSERT(lbl, expr, msg)
`define SRS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

FILE: sv/srs_pkg.sv
// ---------------------------------------------------------------------------
// srs_pkg
// Shared constants, types and helpers of the substring replace stream.
// ---------------------------------------------------------------------------
package srs_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int REPLACE_MAX = 16;

    localparam int BYTE_W      = 8;
    localparam int BYTE_IDX_W  = 4;   // selects one of 16 bytes in a lo/hi pair
    localparam int LEN_W       = 5;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW        = 3'd0,
        CFG_PATTERN_HIGH       = 3'd1,
        CFG_PATTERN_LENGTH     = 3'd2,
        CFG_REPLACEMENT_LOW    = 3'd3,
        CFG_REPLACEMENT_HIGH   = 3'd4,
        CFG_REPLACEMENT_LENGTH = 3'd5,
        CFG_LIMIT_ENABLE       = 3'd6,
        CFG_MAX_REPLACEMENTS   = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               out_last;
        logic [COUNT_W-1:0] replacements_made;
    } t_result;

    typedef struct packed {
        logic load;    // take the incoming byte
        logic shift;   // take the right neighbour's byte
    } t_cell_ctrl;

    function automatic logic [BYTE_W-1:0] byte_at(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [BYTE_IDX_W-1:0] idx
    );
        logic [CFG_DATA_W-1:0] word;
        word = idx[BYTE_IDX_W-1] ? hi : lo;
        return word[{idx[BYTE_IDX_W-2:0], 3'b000} +: BYTE_W];
    endfunction

endpackage

FILE: sv/srs_if.sv
// ---------------------------------------------------------------------------
// srs_in_if / srs_out_if
// Valid/ready channels carrying input bytes and result beats.
// ---------------------------------------------------------------------------
interface srs_in_if;
    logic                       valid;
    logic                       ready;
    logic [srs_pkg::BYTE_W-1:0] in_byte;
    logic                       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface srs_out_if;
    logic                        valid;
    logic                        ready;
    logic [srs_pkg::BYTE_W-1:0]  out_byte;
    logic                        byte_valid;
    logic                        out_last;
    logic [srs_pkg::COUNT_W-1:0] replacements_made;

    modport source (output valid, output out_byte, output byte_valid, output out_last,
                    output replacements_made, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                    input replacements_made, output ready);
endinterface

FILE: sv/substring_replace_stream.sv
// ---------------------------------------------------------------------------
// substring_replace_stream
// Streaming leftmost, non-overlapping substring replacement over a window
// held in a row of byte cells.
// ---------------------------------------------------------------------------
// A string enters one byte per beat on i_in, in_last on its final byte, and
// the rewritten string leaves on o_out one byte per beat; the final beat has
// out_last set and the replacement count, and is a lone marker with byte_valid
// low when the final byte leaves nothing to send. A byte with at most one result
// does not hold the input, so ordinary text streams at one byte per cycle until
// back-pressure on o_out fills the output buffer and stalls the input. A byte
// with k results (a replacement of k bytes, or the window flush on the final
// byte) holds the input until its last result is emitted, since results leave
// the window head or the replacement register one per cycle into the two-entry
// output buffer. The pattern compare is done by all cells at once in the cycle
// after a byte is taken. Configuration must be written only while no string is
// in flight (not enforced by the block); no clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`include "substring_replace_stream_macros.svh"

module substring_replace_stream #(
    parameter int PATTERN_MAX = srs_pkg::PATTERN_MAX,
    parameter int REPLACE_MAX = srs_pkg::REPLACE_MAX
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    srs_in_if.sink                         i_in,
    srs_out_if.source                      o_out
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam int REP_W  = $clog2(REPLACE_MAX + 1);
    localparam int JOB_W  = ((FILL_W > REP_W) ? FILL_W : REP_W) + 1;

    // configuration
    logic [srs_pkg::CFG_DATA_W-1:0] r_pat_lo;
    logic [srs_pkg::CFG_DATA_W-1:0] r_pat_hi;
    logic [srs_pkg::LEN_W-1:0]      r_pat_len;
    logic [srs_pkg::CFG_DATA_W-1:0] r_rep_lo;
    logic [srs_pkg::CFG_DATA_W-1:0] r_rep_hi;
    logic [srs_pkg::LEN_W-1:0]      r_rep_len;
    logic                           r_lim_en;
    logic [srs_pkg::COUNT_W-1:0]    r_max_rep;

    // engine state
    logic [FILL_W-1:0]              r_fill;
    logic                           r_dec;        // newest byte awaits its compare
    logic                           r_item_last;
    logic [REP_W-1:0]               r_rep_left;
    logic [srs_pkg::BYTE_IDX_W-1:0] r_rep_idx;
    logic [FILL_W-1:0]              r_pop_left;
    logic                           r_marker;
    logic                           r_job_last;
    logic [srs_pkg::COUNT_W-1:0]    r_count;

    logic [FILL_W-1:0]              n_fill;
    logic [REP_W-1:0]               n_rep_left;
    logic [srs_pkg::BYTE_IDX_W-1:0] n_rep_idx;
    logic [FILL_W-1:0]              n_pop_left;
    logic                           n_marker;
    logic [srs_pkg::COUNT_W-1:0]    n_count;

    logic [FILL_W-1:0]              s_plen;
    logic [REP_W-1:0]               s_rlen;
    logic [srs_pkg::BYTE_W-1:0]     s_bytes [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]         s_match;
    srs_pkg::t_cell_ctrl            s_ctrl  [PATTERN_MAX];

    logic                           s_full;
    logic                           s_over;
    logic                           s_allowed;
    logic                           s_hit;
    logic [FILL_W-1:0]              d_pop;
    logic [REP_W-1:0]               d_rep;
    logic                           d_marker;

    logic [REP_W-1:0]               e_rep;
    logic [srs_pkg::BYTE_IDX_W-1:0] e_idx;
    logic [FILL_W-1:0]              e_pop;
    logic                           e_marker;
    logic                           e_last;
    logic [srs_pkg::COUNT_W-1:0]    e_count;
    logic [FILL_W-1:0]              e_fill;
    logic [JOB_W-1:0]               e_cnt;

    logic                           s_rep_case;
    logic                           s_pop_case;
    logic                           s_emit;
    logic                           s_shift;
    logic                           s_accept;
    logic [FILL_W-1:0]              s_wr_idx;
    srs_pkg::t_result               s_res;

    logic                           s_buf_full;
    logic                           s_buf_valid;
    srs_pkg::t_result               s_buf_data;

    // -----------------------------------------------------------------------
    // configuration port
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= srs_pkg::LEN_W'(1);
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
            r_rep_len <= '0;
            r_lim_en  <= 1'b0;
            r_max_rep <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (srs_pkg::t_cfg_reg'(i_cfg_index))
                srs_pkg::CFG_PATTERN_LOW:        r_pat_lo  <= i_cfg_data;
                srs_pkg::CFG_PATTERN_HIGH:       r_pat_hi  <= i_cfg_data;
                srs_pkg::CFG_PATTERN_LENGTH:     r_pat_len <= i_cfg_data[srs_pkg::LEN_W-1:0];
                srs_pkg::CFG_REPLACEMENT_LOW:    r_rep_lo  <= i_cfg_data;
                srs_pkg::CFG_REPLACEMENT_HIGH:   r_rep_hi  <= i_cfg_data;
                srs_pkg::CFG_REPLACEMENT_LENGTH: r_rep_len <= i_cfg_data[srs_pkg::LEN_W-1:0];
                srs_pkg::CFG_LIMIT_ENABLE:       r_lim_en  <= i_cfg_data[0];
                srs_pkg::CFG_MAX_REPLACEMENTS:   r_max_rep <= i_cfg_data[srs_pkg::COUNT_W-1:0];
            endcase
        end
    end

    // zero pattern length acts as one; pattern length saturates at the window size, replacement length at REPLACE_MAX
    always_comb begin
        if (r_pat_len == '0) begin
            s_plen = FILL_W'(1);
        end else if (r_pat_len > srs_pkg::LEN_W'(PATTERN_MAX)) begin
            s_plen = FILL_W'(PATTERN_MAX);
        end else begin
            s_plen = FILL_W'(r_pat_len);
        end
        if (r_rep_len > srs_pkg::LEN_W'(REPLACE_MAX)) begin
            s_rlen = REP_W'(REPLACE_MAX);
        end else begin
            s_rlen = REP_W'(r_rep_len);
        end
    end

    // -----------------------------------------------------------------------
    // window cells, head (oldest byte) at cell 0
    // -----------------------------------------------------------------------
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        logic [srs_pkg::BYTE_W-1:0] w_next;

        if (g == PATTERN_MAX - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = s_bytes[g+1];
        end

        assign s_ctrl[g].load  = s_accept && (s_wr_idx == FILL_W'(g));
        assign s_ctrl[g].shift = s_shift;

        srs_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (s_ctrl[g]),
            .i_load_byte (i_in.in_byte),
            .i_next_byte (w_next),
            .i_pat_byte  (srs_pkg::byte_at(r_pat_lo, r_pat_hi,
                                           srs_pkg::BYTE_IDX_W'(g))),
            .i_care      (FILL_W'(g) < s_plen),
            .o_byte      (s_bytes[g]),
            .o_match     (s_match[g])
        );
    end

    // -----------------------------------------------------------------------
    // decision on the newest byte, turned into a job of pops or replacement
    // -----------------------------------------------------------------------
    always_comb begin
        s_full    = (r_fill == s_plen);
        s_over    = (r_fill > s_plen);
        s_allowed = !r_lim_en || (r_count < r_max_rep);
        s_hit     = r_dec && s_full && s_allowed && (&s_match);

        if (s_hit) begin
            d_pop = '0;
        end else if (r_item_last) begin
            d_pop = r_fill;
        end else if (s_over) begin
            // pattern shrank: drain to one short of it, no compare
            d_pop = r_fill - s_plen + FILL_W'(1);
        end else if (s_full) begin
            d_pop = FILL_W'(1);
        end else begin
            d_pop = '0;
        end
        d_rep    = s_hit ? s_rlen : '0;
        d_marker = r_item_last && (d_pop == '0) && (d_rep == '0);

        if (r_dec) begin
            e_rep    = d_rep;
            e_idx    = '0;
            e_pop    = d_pop;
            e_marker = d_marker;
            e_last   = r_item_last;
        end else begin
            e_rep    = r_rep_left;
            e_idx    = r_rep_idx;
            e_pop    = r_pop_left;
            e_marker = r_marker;
            e_last   = r_job_last;
        end

        if (s_hit && (r_count != srs_pkg::COUNT_MAX)) begin
            e_count = r_count + srs_pkg::COUNT_W'(1);
        end else begin
            e_count = r_count;
        end
        e_fill = s_hit ? '0 : r_fill;
        e_cnt  = JOB_W'(e_rep) + JOB_W'(e_pop) + JOB_W'(e_marker);
    end

    // -----------------------------------------------------------------------
    // one result beat per cycle while the output buffer is not full
    // -----------------------------------------------------------------------
    always_comb begin
        s_rep_case = (e_rep != '0);
        s_pop_case = !s_rep_case && (e_pop != '0);
        s_emit     = !s_buf_full && (s_rep_case || s_pop_case || e_marker);
        s_shift    = s_emit && s_pop_case;

        if (s_rep_case) begin
            s_res.out_byte = srs_pkg::byte_at(r_rep_lo, r_rep_hi, e_idx);
        end else if (s_pop_case) begin
            s_res.out_byte = s_bytes[0];
        end else begin
            s_res.out_byte = '0;
        end
        s_res.byte_valid = s_rep_case || s_pop_case;
        s_res.out_last   = e_last && ((s_rep_case && (e_rep == REP_W'(1)))
                                   || (s_pop_case && (e_pop == FILL_W'(1)))
                                   || (!s_rep_case && !s_pop_case && e_marker));
        s_res.replacements_made = s_res.out_last ? e_count : '0;

        // the next byte may enter once this cycle leaves nothing outstanding
        i_in.ready = (e_cnt == '0) || ((e_cnt == JOB_W'(1)) && s_emit);
        s_accept   = i_in.valid && i_in.ready;
        s_wr_idx   = e_fill - FILL_W'(s_shift);

        n_fill     = s_wr_idx + FILL_W'(s_accept);
        n_rep_left = e_rep - REP_W'(s_emit && s_rep_case);
        n_rep_idx  = e_idx + srs_pkg::BYTE_IDX_W'(s_emit && s_rep_case);
        n_pop_left = e_pop - FILL_W'(s_shift);
        n_marker   = e_marker && !s_emit;
        n_count    = (s_emit && s_res.out_last) ? '0 : e_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_dec       <= 1'b0;
            r_item_last <= 1'b0;
            r_rep_left  <= '0;
            r_rep_idx   <= '0;
            r_pop_left  <= '0;
            r_marker    <= 1'b0;
            r_job_last  <= 1'b0;
            r_count     <= '0;
        end else begin
            r_fill     <= n_fill;
            r_dec      <= s_accept;
            r_rep_left <= n_rep_left;
            r_rep_idx  <= n_rep_idx;
            r_pop_left <= n_pop_left;
            r_marker   <= n_marker;
            r_job_last <= e_last;
            r_count    <= n_count;
            if (s_accept) begin
                r_item_last <= i_in.in_last;
            end
        end
    end

    // -----------------------------------------------------------------------
    // output buffer
    // -----------------------------------------------------------------------
    srs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_emit),
        .i_data  (s_res),
        .o_full  (s_buf_full),
        .o_valid (s_buf_valid),
        .i_ready (o_out.ready),
        .o_data  (s_buf_data)
    );

    assign o_out.valid             = s_buf_valid;
    assign o_out.out_byte          = s_buf_data.out_byte;
    assign o_out.byte_valid        = s_buf_data.byte_valid;
    assign o_out.out_last          = s_buf_data.out_last;
    assign o_out.replacements_made = s_buf_data.replacements_made;

    `SRS_ASSERT(a_fill_range, r_fill <= FILL_W'(PATTERN_MAX), "window fill beyond window size")
    `SRS_ASSERT(a_job_exclusive, (r_rep_left == '0) || (r_pop_left == '0), "replacement and pops both pending")
    `SRS_ASSERT_NEXT(a_accept_decides, s_accept, r_dec && (r_rep_left == '0) && (r_pop_left == '0), "taken byte not up for compare")
    `SRS_ASSERT(a_count_on_last, !s_emit || s_res.out_last || (s_res.replacements_made == '0), "count on a non-final beat")

endmodule

FILE: sv/srs_cell.sv
// ---------------------------------------------------------------------------
// srs_cell
// One window position: holds a byte, shifts towards the head, compares it
// against its pattern byte.
// ---------------------------------------------------------------------------
module srs_cell (
    input  logic                       i_clk,
    input  srs_pkg::t_cell_ctrl        i_ctrl,
    input  logic [srs_pkg::BYTE_W-1:0] i_load_byte,
    input  logic [srs_pkg::BYTE_W-1:0] i_next_byte,
    input  logic [srs_pkg::BYTE_W-1:0] i_pat_byte,
    input  logic                       i_care,
    output logic [srs_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_match
);

    logic [srs_pkg::BYTE_W-1:0] r_byte;

    // a load wins over the shift: the new byte lands behind the shifted ones
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_byte <= i_load_byte;
        end else if (i_ctrl.shift) begin
            r_byte <= i_next_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_match = !i_care || (r_byte == i_pat_byte);

endmodule

FILE: sv/srs_out_buf.sv
// ---------------------------------------------------------------------------
// srs_out_buf
// Two-entry result buffer; full flag comes from registers only so the
// engine never sees the downstream ready combinationally.
// ---------------------------------------------------------------------------
`include "substring_replace_stream_macros.svh"

module srs_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  srs_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output srs_pkg::t_result o_data
);

    srs_pkg::t_result r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    logic             s_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign s_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (s_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(s_pop);
        end
    end

    `SRS_ASSERT(a_cnt_range, r_cnt != 2'd3, "result buffer count out of range")
    `SRS_ASSERT(a_no_overflow, !(i_push && o_full), "beat pushed into full result buffer")
    `SRS_ASSERT_NEXT(a_push_shows, i_push && (r_cnt == 2'd0), o_valid, "pushed beat not shown")

endmodule

FILE: sim/tb_substring_replace_stream.sv
// ---------------------------------------------------------------------------
// tb_substring_replace_stream
// Self-checking bench for the streaming substring replace block: strings go in
// byte by byte, a scoreboard rebuilds the rewritten string beat by beat and
// compares every output beat, under random idling and back-pressure.
// ---------------------------------------------------------------------------
module tb_substring_replace_stream ();

    localparam int SETTLE_CYCLES = 24;     // idle wait after the last expected beat
    localparam int QUIET_LIMIT   = 5000;   // cycles without any beat
    localparam int RANDOM_CHARS  = 400;

    // -----------------------------------------------------------------------
    // Scoreboard: predicts the rewritten string and checks output beats
    // -----------------------------------------------------------------------
    class rewrite_scoreboard;
        logic [63:0]                 pat_lo, pat_hi, rep_lo, rep_hi;
        logic [srs_pkg::LEN_W-1:0]   pat_len, rep_len;
        logic                        lim_en;
        logic [srs_pkg::COUNT_W-1:0] max_rep;
        logic [7:0]                  window[srs_pkg::PATTERN_MAX];
        int                          fill;
        logic [srs_pkg::COUNT_W-1:0] count;
        srs_pkg::t_result            expected_beats[$];
        int                          errors;

        function new();
            pat_lo  = '0;
            pat_hi  = '0;
            pat_len = 5'd1;
            rep_lo  = '0;
            rep_hi  = '0;
            rep_len = '0;
            lim_en  = 1'b0;
            max_rep = '0;
            foreach (window[i]) window[i] = 8'h00;
            fill    = 0;
            count   = '0;
            errors  = 0;
        endfunction

        function void write_reg(srs_pkg::t_cfg_reg idx, logic [63:0] d);
            case (idx)
                srs_pkg::CFG_PATTERN_LOW:        pat_lo  = d;
                srs_pkg::CFG_PATTERN_HIGH:       pat_hi  = d;
                srs_pkg::CFG_PATTERN_LENGTH:     pat_len = d[srs_pkg::LEN_W-1:0];
                srs_pkg::CFG_REPLACEMENT_LOW:    rep_lo  = d;
                srs_pkg::CFG_REPLACEMENT_HIGH:   rep_hi  = d;
                srs_pkg::CFG_REPLACEMENT_LENGTH: rep_len = d[srs_pkg::LEN_W-1:0];
                srs_pkg::CFG_LIMIT_ENABLE:       lim_en  = d[0];
                srs_pkg::CFG_MAX_REPLACEMENTS:   max_rep = d[srs_pkg::COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] nth_byte(logic [63:0] lo, logic [63:0] hi, int idx);
            return (idx < 8) ? lo[8*idx +: 8] : hi[8*(idx-8) +: 8];
        endfunction

        function void push_beat(logic [7:0] b, logic has_byte);
            srs_pkg::t_result beat;
            beat.out_byte          = b;
            beat.byte_valid        = has_byte;
            beat.out_last          = 1'b0;
            beat.replacements_made = '0;
            expected_beats.push_back(beat);
        endfunction

        function void emit_oldest();
            if (fill == 0)
                return;
            push_beat(window[0], 1'b1);
            for (int i = 1; i < fill; i++)
                window[i-1] = window[i];
            fill--;
        endfunction

        function void take_char(logic [7:0] ch, logic last);
            int               plen, rlen, n_at_entry;
            bit               allowed, hit;
            srs_pkg::t_result beat;
            plen = (pat_len == 0) ? 1
                 : ((pat_len > srs_pkg::PATTERN_MAX) ? srs_pkg::PATTERN_MAX : int'(pat_len));
            rlen = (rep_len > srs_pkg::REPLACE_MAX) ? srs_pkg::REPLACE_MAX : int'(rep_len);
            n_at_entry = expected_beats.size();

            if (fill >= srs_pkg::PATTERN_MAX)
                emit_oldest();
            window[fill] = ch;
            fill++;

            if (fill > plen) begin
                // pattern was shortened: drain down to one below, no compare
                while (fill > plen - 1)
                    emit_oldest();
            end else if (fill == plen) begin
                allowed = !lim_en || (count < max_rep);
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (window[i] != nth_byte(pat_lo, pat_hi, i))
                        hit = 1'b0;
                if (allowed && hit) begin
                    for (int i = 0; i < rlen; i++)
                        push_beat(nth_byte(rep_lo, rep_hi, i), 1'b1);
                    fill = 0;
                    if (count != srs_pkg::COUNT_MAX)
                        count++;
                end else begin
                    emit_oldest();
                end
            end

            if (last) begin
                while (fill > 0)
                    emit_oldest();
                if (expected_beats.size() == n_at_entry)
                    push_beat(8'h00, 1'b0);
                beat = expected_beats.pop_back();
                beat.out_last          = 1'b1;
                beat.replacements_made = count;
                expected_beats.push_back(beat);
                fill  = 0;
                count = '0;
            end
        endfunction

        function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (want_v !== got_v) begin
                $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_beat(logic [7:0] ob, logic bv, logic ol, logic [15:0] cnt);
            srs_pkg::t_result want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat out_byte=%0h byte_valid=%b out_last=%b count=%0d",
                         $time, ob, bv, ol, cnt);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("out_byte", 16'(want.out_byte), 16'(ob));
            compare_field("byte_valid", 16'(want.byte_valid), 16'(bv));
            compare_field("out_last", 16'(want.out_last), 16'(ol));
            compare_field("replacements_made", want.replacements_made, cnt);
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, reset, DUT
    // -----------------------------------------------------------------------
    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [srs_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [srs_pkg::CFG_DATA_W-1:0] i_cfg_data;

    srs_in_if  in_ch();
    srs_out_if out_ch();

    rewrite_scoreboard sb;

    int         rx_hold    = 0;
    bit         tx_idle_on = 1'b1;
    bit         rx_idle_on = 1'b1;
    int         chars_sent = 0;
    int         quiet_cycles = 0;
    logic [7:0] pat_bytes[srs_pkg::PATTERN_MAX];
    int         pat_eff;
    logic [7:0] alpha[3];

    always #5 i_clk = ~i_clk;

    substring_replace_stream i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // -----------------------------------------------------------------------
    // Output side: back-pressure, beat check, watchdog
    // -----------------------------------------------------------------------
    initial begin : rx_side
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_beat(out_ch.out_byte, out_ch.byte_valid, out_ch.out_last,
                          out_ch.replacements_made);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_substring_replace_stream failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Input side and register writes
    // -----------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_idle_on || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(20, 50);
    endfunction

    task automatic push_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= ch;
        in_ch.in_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sb.take_char(ch, last);
    endtask

    // stop sending and let every expected beat come out
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (sb.expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input srs_pkg::t_cfg_reg idx, input logic [63:0] d);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
    endtask

    task automatic load_settings(input logic [63:0] pl, input logic [63:0] ph,
                                 input logic [63:0] plen, input logic [63:0] rl,
                                 input logic [63:0] rh, input logic [63:0] rlen,
                                 input logic [63:0] lim, input logic [63:0] maxr);
        set_reg(srs_pkg::CFG_PATTERN_LOW, pl);
        set_reg(srs_pkg::CFG_PATTERN_HIGH, ph);
        set_reg(srs_pkg::CFG_PATTERN_LENGTH, plen);
        set_reg(srs_pkg::CFG_REPLACEMENT_LOW, rl);
        set_reg(srs_pkg::CFG_REPLACEMENT_HIGH, rh);
        set_reg(srs_pkg::CFG_REPLACEMENT_LENGTH, rlen);
        set_reg(srs_pkg::CFG_LIMIT_ENABLE, lim);
        set_reg(srs_pkg::CFG_MAX_REPLACEMENTS, maxr);
        i_cfg_wr_en <= 1'b0;
    endtask

    // narrow registers sometimes get junk above their width
    function automatic logic [63:0] junk_upper(logic [63:0] v, int w);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0)
            return v;
        return (r << w) | v;
    endfunction

    task automatic random_settings(input int phase);
        logic [63:0] pl, ph, rl, rh, plen, rlen, lim, maxr;
        int          r;
        for (int i = 0; i < 3; i++)
            alpha[i] = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 19);
        if (phase == 0)
            plen = 1;
        else if (phase == 1)
            plen = 64'(srs_pkg::PATTERN_MAX);
        else if (phase == 2)
            plen = 2;
        else if (r < 12)
            plen = 64'($urandom_range(1, 4));
        else if (r < 16)
            plen = 64'($urandom_range(5, srs_pkg::PATTERN_MAX));
        else if (r < 18)
            plen = 0;
        else
            plen = 64'($urandom_range(17, 31));
        pat_eff = (plen == 0) ? 1
                : ((plen > srs_pkg::PATTERN_MAX) ? srs_pkg::PATTERN_MAX : int'(plen));

        pl = {$urandom, $urandom};
        ph = {$urandom, $urandom};
        for (int i = 0; i < pat_eff; i++) begin
            pat_bytes[i] = alpha[$urandom_range(0, 2)];
            if (i < 8)
                pl[8*i +: 8] = pat_bytes[i];
            else
                ph[8*(i-8) +: 8] = pat_bytes[i];
        end

        r = $urandom_range(0, 9);
        if (phase == 1 || phase == 2)
            rlen = 64'(srs_pkg::REPLACE_MAX);
        else if (r < 8)
            rlen = 64'($urandom_range(0, srs_pkg::REPLACE_MAX));
        else
            rlen = 64'($urandom_range(17, 31));
        rl = {$urandom, $urandom};
        rh = {$urandom, $urandom};

        r = $urandom_range(0, 9);
        if (phase == 1) begin
            lim  = 1;
            maxr = 64'(srs_pkg::COUNT_MAX);
        end else begin
            lim = 64'($urandom_range(0, 1));
            if (r < 6)
                maxr = 64'($urandom_range(0, 3));
            else if (r < 7)
                maxr = 64'(srs_pkg::COUNT_MAX);
            else
                maxr = 64'($urandom_range(0, 65535));
        end
        load_settings(pl, ph, junk_upper(plen, srs_pkg::LEN_W), rl, rh,
                      junk_upper(rlen, srs_pkg::LEN_W),
                      junk_upper(lim, 1), junk_upper(maxr, srs_pkg::COUNT_W));
    endtask

    // one string, mostly pattern copies and prefixes over a small alphabet
    task automatic send_text();
        logic [7:0] text[$];
        int         target, k, r;
        target = $urandom_range(1, 2 * pat_eff + 8);
        while (text.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                for (int i = 0; i < pat_eff; i++)
                    text.push_back(pat_bytes[i]);
            end else if (r < 55) begin
                k = $urandom_range(1, pat_eff);
                for (int i = 0; i < k; i++)
                    text.push_back(pat_bytes[i]);
            end else if (r < 88) begin
                text.push_back(alpha[$urandom_range(0, 2)]);
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        while (text.size() > target)
            void'(text.pop_back());
        foreach (text[i])
            push_char(text[i], i == text.size() - 1);
        chars_sent += text.size();
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin : stimulus
        logic [63:0] pl, ph, rl, rh;
        int          phase, strings;
        sb = new();
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = srs_pkg::CFG_PATTERN_LOW;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one NUL pattern byte, matches deleted -> lone end marker
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b0);
        push_char(8'h01, 1'b1);

        // "ab" with an over-long replacement, only one replacement allowed
        wait_idle();
        pl = {$urandom, $urandom};
        pl[15:0] = 16'h6261;
        load_settings(pl, {$urandom, $urandom}, 2, {$urandom, $urandom},
                      {$urandom, $urandom}, 31, 1, 1);
        push_char(8'h61, 1'b0);
        push_char(8'h62, 1'b0);
        push_char(8'h61, 1'b0);
        push_char(8'h62, 1'b1);

        // full-width pattern, then the length is cut to two with five bytes held
        wait_idle();
        load_settings('1, '1, 31, {$urandom, $urandom}, {$urandom, $urandom}, 0, 1,
                      64'(srs_pkg::COUNT_MAX));
        for (int k = 0; k < 5; k++)
            push_char(8'(8'h11 * (k + 1)), 1'b0);
        wait_idle();
        set_reg(srs_pkg::CFG_PATTERN_LENGTH, 2);
        i_cfg_wr_en <= 1'b0;
        push_char(8'hFF, 1'b0);
        push_char(8'hFF, 1'b1);

        // zero pattern length acts as one; a match turns into a NUL byte
        wait_idle();
        pl = {$urandom, $urandom};
        pl[7:0] = 8'hFF;
        ph = {$urandom, $urandom};
        rl = {$urandom, $urandom};
        rl[7:0] = 8'h00;
        rh = {$urandom, $urandom};
        load_settings(pl, ph, 0, rl, rh, 1, 0, 0);
        push_char(8'hFF, 1'b0);
        push_char(8'h7F, 1'b1);

        // limit of zero: nothing is replaced
        wait_idle();
        load_settings(pl, ph, 0, rl, rh, 1, 1, 0);
        push_char(8'hFF, 1'b1);

        // random settings and strings
        chars_sent = 0;
        phase = 0;
        while (chars_sent < RANDOM_CHARS) begin
            wait_idle();
            random_settings(phase);
            tx_idle_on = (phase != 0) && ($urandom_range(0, 4) != 0);
            rx_idle_on = (phase != 0) && ($urandom_range(0, 4) != 0);
            if (phase == 2)
                rx_hold = 400;   // output blocked long enough to back up the input
            strings = $urandom_range(3, 6);
            repeat (strings) send_text();
            phase++;
        end

        wait_idle();
        if (sb.errors == 0)
            $display("tb_substring_replace_stream passed");
        else
            $display("tb_substring_replace_stream failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/srs_pkg.sv
sv/srs_if.sv
sv/srs_cell.sv
sv/srs_out_buf.sv
sv/substring_replace_stream.sv
sim/tb_substring_replace_stream.sv
